@@ sv/dep_pkg.sv @@
// ----------------------------------------------------------------------------
// dep_pkg: shared types and constants of the dual encoder period meter
// Command codes, register indexes, the fixed stop period and the request
// bundle that launches one IIR division lane.
// ----------------------------------------------------------------------------
package dep_pkg;

  // Command codes of an input beat
  localparam logic [1:0] CMD_TICK = 2'd0;
  localparam logic [1:0] CMD_PIN  = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_EDGE_WEIGHT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_WEIGHT = 1'b1;

  localparam logic [7:0] EDGE_WEIGHT_RST = 8'd2;
  localparam logic [7:0] STOP_WEIGHT_RST = 8'd16;

  localparam logic [31:0] STOP_PERIOD = 32'd1000000;
  localparam logic [15:0] OVF_MAX     = 16'hffff;
  localparam logic [15:0] DECAY_MASK  = 16'd63;

  // Dividend of one IIR step: old * (w - 1) + x stays below 2^40
  localparam int unsigned ACC_W     = 40;
  localparam int unsigned DIV_STEPS = ACC_W;
  localparam int unsigned CNT_W     = $clog2(DIV_STEPS + 2);

  typedef struct packed {
    logic        start;
    logic [31:0] old_value;
    logic [31:0] sample;
    logic [7:0]  weight;
  } iir_req_t;

endpackage

@@ sv/dep_if.sv @@
// ----------------------------------------------------------------------------
// dep_in_if / dep_out_if: valid-ready channels of the period meter
// One beat moves one command item in, or one result item out.
// ----------------------------------------------------------------------------
interface dep_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        cmd;
  logic              pin_a;
  logic              pin_b;
  logic [15:0]       timer_now;
  logic              overflow_pending;
  logic signed [1:0] dir_a;
  logic signed [1:0] dir_b;

  modport source (
    output valid, cmd, pin_a, pin_b, timer_now, overflow_pending, dir_a, dir_b,
    input  ready
  );
  modport sink (
    input  valid, cmd, pin_a, pin_b, timer_now, overflow_pending, dir_a, dir_b,
    output ready
  );
endinterface

interface dep_out_if;
  logic               valid;
  logic               ready;
  logic [31:0]        period_a;
  logic [31:0]        period_b;
  logic signed [63:0] position_a;
  logic signed [63:0] position_b;
  logic signed [15:0] short_count_a;
  logic signed [15:0] short_count_b;
  logic               edge_seen_a;
  logic               edge_seen_b;

  modport source (
    output valid, period_a, period_b, position_a, position_b,
           short_count_a, short_count_b, edge_seen_a, edge_seen_b,
    input  ready
  );
  modport sink (
    input  valid, period_a, period_b, position_a, position_b,
           short_count_a, short_count_b, edge_seen_a, edge_seen_b,
    output ready
  );
endinterface

@@ sv/dep_iir_div.sv @@
// ----------------------------------------------------------------------------
// dep_iir_div: one IIR averaging step, bit-serial divide
// Computes (old * (w - 1) + x) / w with w of 0 taken as 1: it first forms
// the 40-bit dividend, then produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dep_iir_div
  import dep_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  iir_req_t    req,
  output logic        busy,
  output logic [31:0] result
);

  localparam logic [CNT_W-1:0] CNT_LOAD = CNT_W'(DIV_STEPS + 1);

  logic [CNT_W-1:0] cnt_r;
  logic [31:0]      old_r;
  logic [31:0]      x_r;
  logic [7:0]       d_r;
  logic [ACC_W-1:0] acc_r;
  logic [7:0]       rem_r;

  logic [7:0]       dm1;
  logic [ACC_W-1:0] prod;
  logic [8:0]       rem_sh;
  logic [8:0]       rem_diff;
  logic             q_bit;

  assign dm1      = d_r - 8'd1;
  assign prod     = {{(ACC_W-32){1'b0}}, old_r} * {{(ACC_W-8){1'b0}}, dm1};
  assign rem_sh   = {rem_r, acc_r[ACC_W-1]};
  assign rem_diff = rem_sh - {1'b0, d_r};
  assign q_bit    = (rem_sh >= {1'b0, d_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (req.start) begin
      cnt_r <= CNT_LOAD;
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      old_r <= req.old_value;
      x_r   <= req.sample;
      d_r   <= (req.weight == 8'd0) ? 8'd1 : req.weight;
    end else if (cnt_r == CNT_LOAD) begin
      acc_r <= prod + {{(ACC_W-32){1'b0}}, x_r};
      rem_r <= '0;
    end else if (cnt_r != '0) begin
      // shift the next dividend bit into the remainder, the quotient bit in at the bottom
      acc_r <= {acc_r[ACC_W-2:0], q_bit};
      rem_r <= q_bit ? rem_diff[7:0] : rem_sh[7:0];
    end
  end

  assign busy   = (cnt_r != '0);
  assign result = acc_r[31:0];

endmodule

@@ sv/dual_encoder_period_meter_unit.sv @@
// ----------------------------------------------------------------------------
// dual_encoder_period_meter_unit: speed and position of two wheel encoders
// Measures edge periods with IIR averaging and keeps edge counts per motor.
// ----------------------------------------------------------------------------
// Usage:
//   in_bus carries one command beat: a timer overflow tick, a pin event
//   with the sampled levels, timer capture, pending-overflow flag and the
//   count directions, or a read that reports and clears the short counts.
//   out_bus returns exactly one result beat per command: both averaged
//   periods, both 64-bit positions, both short counts and the edge flags.
//   cfg_we/cfg_index/cfg_data write the two averaging weights; write them
//   only while no command is in flight.
// Timing:
//   One command at a time; in_ready rises in the same cycle as out_valid.
//   A command that needs no average update retires as soon as the result
//   slot is free. A command that updates an average (a falling edge, or a
//   tick that lands on a multiple of 64) first runs the bit-serial divider
//   that each motor has of its own: it forms the 40-bit dividend, then the
//   quotient bit by bit; the result retires once both dividers are idle
//   and the result slot is free.
// Reset: rst_n is synchronous and active low; it clears all counts,
//   periods and levels and loads the default weights (2 and 16).
// Stall: the result register holds its beat while out_ready is low; a
//   new command is still taken and waits in the run state for the slot.
// ----------------------------------------------------------------------------
module dual_encoder_period_meter_unit
  import dep_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  dep_in_if.sink               in_bus,
  dep_out_if.source            out_bus,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  // Configuration
  logic [7:0] edge_w_r;
  logic [7:0] stop_w_r;

  // Per-motor state, lane 0 is motor A and lane 1 motor B
  logic               last_level_r [2];
  logic [15:0]        ovf_r        [2];
  logic [15:0]        cap_r        [2];
  logic [31:0]        avg_r        [2];
  logic [15:0]        short_r      [2];
  logic [63:0]        pos_r        [2];

  // Command in flight
  logic       state_r;
  logic [1:0] cmd_r;
  logic       edge_r [2];
  logic       run_r  [2];

  // Result register
  logic        out_valid_r;
  logic [31:0] out_period_r [2];
  logic [63:0] out_pos_r    [2];
  logic [15:0] out_short_r  [2];
  logic        out_edge_r   [2];

  // Lane decode of the incoming beat
  logic              pin_v    [2];
  logic signed [1:0] dir_v    [2];
  logic [15:0]       ovf_inc  [2];
  logic              decay    [2];
  logic              edge_now [2];
  logic [16:0]       ovf_sum  [2];
  logic [33:0]       diff     [2];
  logic [32:0]       elapsed  [2];
  logic [31:0]       sample_p [2];
  iir_req_t          req      [2];
  logic              div_busy [2];
  logic [31:0]       div_res  [2];

  logic accept;
  logic finish;
  logic is_tick;
  logic is_pin;

  assign pin_v[0] = in_bus.pin_a;
  assign pin_v[1] = in_bus.pin_b;
  assign dir_v[0] = in_bus.dir_a;
  assign dir_v[1] = in_bus.dir_b;

  assign in_bus.ready = (state_r == ST_IDLE);
  assign accept  = in_bus.valid && in_bus.ready;
  assign is_tick = (in_bus.cmd == CMD_TICK);
  assign is_pin  = (in_bus.cmd == CMD_PIN);

  // Retire once both dividers are idle and the result slot is free
  assign finish = (state_r == ST_RUN) && !div_busy[0] && !div_busy[1] &&
                  (!out_valid_r || out_bus.ready);

  always_comb begin
    for (int m = 0; m < 2; m++) begin
      ovf_inc[m]  = (ovf_r[m] == OVF_MAX) ? ovf_r[m] : ovf_r[m] + 16'd1;
      decay[m]    = ((ovf_inc[m] & DECAY_MASK) == 16'd0);
      edge_now[m] = last_level_r[m] && !pin_v[m];
      // elapsed = (overflows + pending) * 65536 + now - capture
      ovf_sum[m]  = {1'b0, ovf_r[m]} + {16'd0, in_bus.overflow_pending};
      diff[m]     = {1'b0, ovf_sum[m], in_bus.timer_now} - {18'd0, cap_r[m]};
      // a negative span wraps to 32 bits, a positive one keeps bit 32
      elapsed[m]  = diff[m][33] ? {1'b0, diff[m][31:0]} : diff[m][32:0];
      sample_p[m] = {2'b00, elapsed[m][32:3]};

      req[m].start     = accept && ((is_tick && decay[m]) || (is_pin && edge_now[m]));
      req[m].old_value = avg_r[m];
      req[m].sample    = is_tick ? STOP_PERIOD : sample_p[m];
      req[m].weight    = is_tick ? stop_w_r : edge_w_r;
    end
  end

  for (genvar g = 0; g < 2; g++) begin : g_lane
    dep_iir_div u_div (
      .clk    (clk),
      .rst_n  (rst_n),
      .req    (req[g]),
      .busy   (div_busy[g]),
      .result (div_res[g])
    );
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      edge_w_r <= EDGE_WEIGHT_RST;
      stop_w_r <= STOP_WEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_EDGE_WEIGHT: edge_w_r <= cfg_data;
        REG_STOP_WEIGHT: stop_w_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer: idle until a beat arrives, run until the result retires
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      cmd_r       <= CMD_TICK;
      for (int m = 0; m < 2; m++) begin
        edge_r[m] <= 1'b0;
        run_r[m]  <= 1'b0;
      end
    end else begin
      if (accept) begin
        state_r <= ST_RUN;
        cmd_r   <= in_bus.cmd;
        for (int m = 0; m < 2; m++) begin
          edge_r[m] <= is_pin && edge_now[m];
          run_r[m]  <= req[m].start;
        end
      end else if (finish) begin
        state_r <= ST_IDLE;
      end

      if (finish) begin
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Motor state: counts move on acceptance, averages land on retirement
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int m = 0; m < 2; m++) begin
        last_level_r[m] <= 1'b0;
        ovf_r[m]        <= '0;
        cap_r[m]        <= '0;
        avg_r[m]        <= '0;
        short_r[m]      <= '0;
        pos_r[m]        <= '0;
      end
    end else begin
      for (int m = 0; m < 2; m++) begin
        if (accept && is_tick) begin
          ovf_r[m] <= ovf_inc[m];
        end
        if (accept && is_pin) begin
          last_level_r[m] <= pin_v[m];
          if (edge_now[m]) begin
            ovf_r[m]   <= '0;
            cap_r[m]   <= in_bus.timer_now;
            short_r[m] <= short_r[m] + {{14{dir_v[m][1]}}, dir_v[m]};
            pos_r[m]   <= pos_r[m] + {{62{dir_v[m][1]}}, dir_v[m]};
          end
        end
        if (finish) begin
          if (run_r[m]) begin
            avg_r[m] <= div_res[m];
          end
          // report the count first, then drop it
          if (cmd_r == CMD_READ) begin
            short_r[m] <= '0;
          end
        end
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (finish) begin
      for (int m = 0; m < 2; m++) begin
        out_period_r[m] <= run_r[m] ? div_res[m] : avg_r[m];
        out_pos_r[m]    <= pos_r[m];
        out_short_r[m]  <= short_r[m];
        out_edge_r[m]   <= edge_r[m];
      end
    end
  end

  assign out_bus.valid         = out_valid_r;
  assign out_bus.period_a      = out_period_r[0];
  assign out_bus.period_b      = out_period_r[1];
  assign out_bus.position_a    = out_pos_r[0];
  assign out_bus.position_b    = out_pos_r[1];
  assign out_bus.short_count_a = out_short_r[0];
  assign out_bus.short_count_b = out_short_r[1];
  assign out_bus.edge_seen_a   = out_edge_r[0];
  assign out_bus.edge_seen_b   = out_edge_r[1];

endmodule

@@ sv/dep_checker.sv @@
// ----------------------------------------------------------------------------
// dep_checker: port-level checks of the period meter
// Watches both channels and flags sequencing slips.
// ----------------------------------------------------------------------------
module dep_checker
  import dep_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  in_cmd,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_period_a,
  input logic        out_edge_seen_a,
  input logic        out_edge_seen_b
);

  logic [1:0] head_cmd_r;
  logic [1:0] tail_cmd_r;
  logic [1:0] open_r;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // track the commands whose results are still owed, oldest first
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_cmd_r <= CMD_TICK;
      tail_cmd_r <= CMD_TICK;
      open_r     <= '0;
    end else if (in_acc && !out_acc) begin
      if (open_r == 2'd0) begin
        head_cmd_r <= in_cmd;
      end else begin
        tail_cmd_r <= in_cmd;
      end
      open_r <= open_r + 2'd1;
    end else if (!in_acc && out_acc) begin
      head_cmd_r <= tail_cmd_r;
      open_r     <= open_r - 2'd1;
    end else if (in_acc && out_acc) begin
      if (open_r == 2'd1) begin
        head_cmd_r <= in_cmd;
      end else begin
        head_cmd_r <= tail_cmd_r;
        tail_cmd_r <= in_cmd;
      end
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_period_a))
    else $error("result beat dropped or changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second command taken while one is in flight");

  a_edge_on_pin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_edge_seen_a || out_edge_seen_b) |-> head_cmd_r == CMD_PIN)
    else $error("edge flag reported for a command other than a pin event");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind dual_encoder_period_meter_unit dep_checker u_dep_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_bus.valid),
  .in_ready        (in_bus.ready),
  .in_cmd          (in_bus.cmd),
  .out_valid       (out_bus.valid),
  .out_ready       (out_bus.ready),
  .out_period_a    (out_bus.period_a),
  .out_edge_seen_a (out_bus.edge_seen_a),
  .out_edge_seen_b (out_bus.edge_seen_b)
);

@@ bench/tb_dual_encoder_period_meter_unit.sv @@
// ----------------------------------------------------------------------------
// tb_dual_encoder_period_meter_unit: self-checking bench of the period meter
// Drives command beats over the valid-ready input channel, predicts every
// result beat with a local model of both encoder lanes and compares each
// returned beat field by field, with random idling on both sides and
// several weight settings written between phases.
// ----------------------------------------------------------------------------
module tb_dual_encoder_period_meter_unit;
  import dep_pkg::*;

  // Command code that the block has no use for; it must report state only
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  // Measured periods are kept in timer units divided by this
  localparam logic [63:0] PERIOD_DIV = 64'd8;
  localparam int unsigned LIMIT_CYCLES = 4000000;
  localparam int unsigned TAIL_CYCLES  = 60;
  localparam int unsigned RANDOM_PER_PHASE = 30;

  typedef struct {
    logic [1:0]        cmd;
    logic              pin_a;
    logic              pin_b;
    logic [15:0]       timer_now;
    logic              pend;
    logic signed [1:0] dir_a;
    logic signed [1:0] dir_b;
  } meter_beat_t;

  typedef struct {
    logic [31:0]        period_a;
    logic [31:0]        period_b;
    logic signed [63:0] position_a;
    logic signed [63:0] position_b;
    logic signed [15:0] short_count_a;
    logic signed [15:0] short_count_b;
    logic               edge_seen_a;
    logic               edge_seen_b;
  } meter_report_t;

  // One row of the directed table; known rows carry a zero report typed in
  typedef struct {
    meter_beat_t beat;
    int          reps;
    bit          known_zero;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [7:0]           cfg_data;

  dep_in_if  in_ch ();
  dep_out_if out_ch ();

  dual_encoder_period_meter_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (in_ch),
    .out_bus   (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Local model of the two encoder lanes
  // --------------------------------------------------------------------------
  logic        lane_level [2];
  logic [15:0] ovf_count  [2];
  logic [15:0] capture    [2];
  logic [31:0] avg_period [2];
  logic [15:0] short_cnt  [2];
  logic [63:0] position   [2];
  logic [7:0]  edge_weight;
  logic [7:0]  stop_weight;

  meter_report_t report_q [$];
  int errors = 0;

  // Beat-side tag: a directed row may replace the prediction by a typed report
  logic known_tag;
  bit   calm = 1'b0;

  function automatic void clear_meter();
    for (int m = 0; m < 2; m++) begin
      lane_level[m] = 1'b0;
      ovf_count[m]  = '0;
      capture[m]    = '0;
      avg_period[m] = '0;
      short_cnt[m]  = '0;
      position[m]   = '0;
    end
    edge_weight = EDGE_WEIGHT_RST;
    stop_weight = STOP_WEIGHT_RST;
  endfunction

  // One IIR step; a weight of zero acts as one, so the sample replaces the mean
  function automatic logic [31:0] iir_blend(logic [31:0] old_value, logic [31:0] sample,
                                            logic [7:0] weight);
    logic [63:0] div;
    logic [63:0] acc;
    div = (weight == 8'd0) ? 64'd1 : {56'd0, weight};
    acc = {32'd0, old_value} * (div - 64'd1) + {32'd0, sample};
    return 32'(acc / div);
  endfunction

  // Advance both lanes by one command beat and return the report it causes
  function automatic meter_report_t advance_meter(meter_beat_t b);
    meter_report_t r;
    logic [1:0]  pin;
    logic [1:0]  dir [2];
    logic [1:0]  hit;
    logic [63:0] elapsed;
    logic [63:0] step;
    logic [15:0] shown [2];
    pin    = {b.pin_b, b.pin_a};
    dir[0] = b.dir_a;
    dir[1] = b.dir_b;
    hit    = 2'b00;
    case (b.cmd)
      CMD_TICK: begin
        for (int m = 0; m < 2; m++) begin
          if (ovf_count[m] < OVF_MAX) ovf_count[m]++;
          // a saturated count is not a multiple of 64, so decay stops there
          if ((ovf_count[m] & DECAY_MASK) == 16'd0)
            avg_period[m] = iir_blend(avg_period[m], STOP_PERIOD, stop_weight);
        end
      end
      CMD_PIN: begin
        for (int m = 0; m < 2; m++) begin
          if (pin[m] != lane_level[m]) begin
            lane_level[m] = pin[m];
            if (!pin[m]) hit[m] = 1'b1;
          end
        end
        for (int m = 0; m < 2; m++) begin
          if (hit[m]) begin
            elapsed = (({48'd0, ovf_count[m]} + {63'd0, b.pend}) << 16) + {48'd0, b.timer_now};
            // a capture ahead of the timer with no overflow wraps at 32 bits
            if (elapsed >= {48'd0, capture[m]})
              elapsed = elapsed - {48'd0, capture[m]};
            else
              elapsed = (elapsed + 64'h1_0000_0000 - {48'd0, capture[m]}) & 64'hffff_ffff;
            avg_period[m] = iir_blend(avg_period[m], 32'(elapsed / PERIOD_DIV), edge_weight);
            ovf_count[m]  = '0;
            capture[m]    = b.timer_now;
            step          = {{62{dir[m][1]}}, dir[m]};
            short_cnt[m]  = short_cnt[m] + step[15:0];
            position[m]   = position[m] + step;
          end
        end
      end
      default: ;
    endcase
    shown[0] = short_cnt[0];
    shown[1] = short_cnt[1];
    if (b.cmd == CMD_READ) begin
      short_cnt[0] = '0;
      short_cnt[1] = '0;
    end
    r.period_a      = avg_period[0];
    r.period_b      = avg_period[1];
    r.position_a    = position[0];
    r.position_b    = position[1];
    r.short_count_a = shown[0];
    r.short_count_b = shown[1];
    r.edge_seen_a   = hit[0];
    r.edge_seen_b   = hit[1];
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Monitor and checker: predict on each input beat, compare each result beat
  // --------------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  int stall_left = 0;

  always @(posedge clk) begin
    meter_beat_t   b;
    meter_report_t want;
    meter_report_t got;
    if (in_ch.valid && in_ch.ready) begin
      b.cmd       = in_ch.cmd;
      b.pin_a     = in_ch.pin_a;
      b.pin_b     = in_ch.pin_b;
      b.timer_now = in_ch.timer_now;
      b.pend      = in_ch.overflow_pending;
      b.dir_a     = in_ch.dir_a;
      b.dir_b     = in_ch.dir_b;
      want = advance_meter(b);
      // typed rows expect an all-zero report in place of the prediction
      if (known_tag) want = '{default: '0};
      report_q.push_back(want);
    end
    if (out_ch.valid && out_ch.ready) begin
      got.period_a      = out_ch.period_a;
      got.period_b      = out_ch.period_b;
      got.position_a    = out_ch.position_a;
      got.position_b    = out_ch.position_b;
      got.short_count_a = out_ch.short_count_a;
      got.short_count_b = out_ch.short_count_b;
      got.edge_seen_a   = out_ch.edge_seen_a;
      got.edge_seen_b   = out_ch.edge_seen_b;
      if (report_q.size() == 0) begin
        $error("result beat with no report expected");
        errors++;
      end else begin
        want = report_q.pop_front();
        if (got.period_a !== want.period_a) begin
          $error("period_a: expected %0d, got %0d", want.period_a, got.period_a);
          errors++;
        end
        if (got.period_b !== want.period_b) begin
          $error("period_b: expected %0d, got %0d", want.period_b, got.period_b);
          errors++;
        end
        if (got.position_a !== want.position_a) begin
          $error("position_a: expected %0d, got %0d", want.position_a, got.position_a);
          errors++;
        end
        if (got.position_b !== want.position_b) begin
          $error("position_b: expected %0d, got %0d", want.position_b, got.position_b);
          errors++;
        end
        if (got.short_count_a !== want.short_count_a) begin
          $error("short_count_a: expected %0d, got %0d", want.short_count_a,
                 got.short_count_a);
          errors++;
        end
        if (got.short_count_b !== want.short_count_b) begin
          $error("short_count_b: expected %0d, got %0d", want.short_count_b,
                 got.short_count_b);
          errors++;
        end
        if (got.edge_seen_a !== want.edge_seen_a) begin
          $error("edge_seen_a: expected %0d, got %0d", want.edge_seen_a, got.edge_seen_a);
          errors++;
        end
        if (got.edge_seen_b !== want.edge_seen_b) begin
          $error("edge_seen_b: expected %0d, got %0d", want.edge_seen_b, got.edge_seen_b);
          errors++;
        end
      end
    end
    // Result side stalls: one assignment of ready per edge
    if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left--;
    end else begin
      out_ch.ready <= 1'b1;
      if (!calm && $urandom_range(0, 3) == 0) stall_left = pick_gap();
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Present one beat, hold it until taken, then idle for a random gap
  task automatic drive_beat(meter_beat_t b, bit known);
    int gap;
    in_ch.valid            <= 1'b1;
    in_ch.cmd              <= b.cmd;
    in_ch.pin_a            <= b.pin_a;
    in_ch.pin_b            <= b.pin_b;
    in_ch.timer_now        <= b.timer_now;
    in_ch.overflow_pending <= b.pend;
    in_ch.dir_a            <= b.dir_a;
    in_ch.dir_b            <= b.dir_b;
    known_tag              <= known;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop valid and hold until every expected report has come back
  task automatic drain_meter();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (report_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_weight(logic [CFG_IDX_W-1:0] idx, logic [7:0] value);
    drain_meter();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_EDGE_WEIGHT) edge_weight = value;
    else stop_weight = value;
  endtask

  function automatic meter_beat_t make_beat(logic [1:0] cmd, logic pa, logic pb,
                                            logic [15:0] tmr, logic pend,
                                            logic [1:0] da, logic [1:0] db);
    meter_beat_t b;
    b.cmd = cmd; b.pin_a = pa; b.pin_b = pb; b.timer_now = tmr;
    b.pend = pend; b.dir_a = da; b.dir_b = db;
    return b;
  endfunction

  // Mostly pin events and ticks; reads and the unused code now and then
  function automatic meter_beat_t random_beat();
    int r;
    logic [1:0] cmd;
    r = $urandom_range(0, 99);
    if (r < 35)      cmd = CMD_TICK;
    else if (r < 85) cmd = CMD_PIN;
    else if (r < 95) cmd = CMD_READ;
    else             cmd = CMD_UNUSED;
    return make_beat(cmd, 1'($urandom), 1'($urandom), 16'($urandom), 1'($urandom),
                     2'($urandom), 2'($urandom));
  endfunction

  // --------------------------------------------------------------------------
  // Directed table: reset state, unused code, falling edges with a wrapped
  // elapsed time and odd directions, read and clear, decay after 64 ticks
  // --------------------------------------------------------------------------
  stim_row_t rows [] = '{
    '{make_beat(CMD_READ,   1'b0, 1'b0, 16'h0000, 1'b0, 2'b00, 2'b00),  1, 1'b1},
    '{make_beat(CMD_UNUSED, 1'b1, 1'b1, 16'hffff, 1'b1, 2'b11, 2'b11),  1, 1'b1},
    '{make_beat(CMD_TICK,   1'b1, 1'b1, 16'hffff, 1'b1, 2'b01, 2'b01),  1, 1'b1},
    '{make_beat(CMD_PIN,    1'b1, 1'b1, 16'h1234, 1'b0, 2'b01, 2'b01),  1, 1'b1},
    '{make_beat(CMD_PIN,    1'b0, 1'b0, 16'hffff, 1'b1, 2'b01, 2'b11),  1, 1'b0},
    '{make_beat(CMD_PIN,    1'b1, 1'b0, 16'h0000, 1'b0, 2'b01, 2'b01),  1, 1'b0},
    '{make_beat(CMD_PIN,    1'b0, 1'b1, 16'h0000, 1'b0, 2'b10, 2'b00),  1, 1'b0},
    '{make_beat(CMD_PIN,    1'b0, 1'b0, 16'h8000, 1'b1, 2'b00, 2'b10),  1, 1'b0},
    '{make_beat(CMD_READ,   1'b1, 1'b1, 16'hffff, 1'b1, 2'b11, 2'b11),  1, 1'b0},
    '{make_beat(CMD_READ,   1'b0, 1'b0, 16'h0000, 1'b0, 2'b00, 2'b00),  1, 1'b0},
    '{make_beat(CMD_TICK,   1'b0, 1'b0, 16'h0000, 1'b0, 2'b00, 2'b00), 64, 1'b0},
    '{make_beat(CMD_TICK,   1'b0, 1'b0, 16'h0000, 1'b0, 2'b00, 2'b00),  1, 1'b0},
    '{make_beat(CMD_PIN,    1'b1, 1'b1, 16'h7fff, 1'b0, 2'b11, 2'b01),  1, 1'b0},
    '{make_beat(CMD_PIN,    1'b0, 1'b0, 16'h0001, 1'b1, 2'b11, 2'b01),  1, 1'b0},
    '{make_beat(CMD_READ,   1'b0, 1'b0, 16'h0000, 1'b0, 2'b00, 2'b00),  1, 1'b0}
  };

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [7:0] edge_set [5];
    logic [7:0] stop_set [5];
    int burst;
    meter_beat_t b;

    // Every input known from the first instant
    rst_n                  = 1'b0;
    cfg_we                 = 1'b0;
    cfg_index              = '0;
    cfg_data               = '0;
    in_ch.valid            = 1'b0;
    in_ch.cmd              = CMD_TICK;
    in_ch.pin_a            = 1'b0;
    in_ch.pin_b            = 1'b0;
    in_ch.timer_now        = '0;
    in_ch.overflow_pending = 1'b0;
    in_ch.dir_a            = '0;
    in_ch.dir_b            = '0;
    known_tag              = 1'b0;
    clear_meter();

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed rows run at the reset weights
    foreach (rows[i])
      repeat (rows[i].reps) drive_beat(rows[i].beat, rows[i].known_zero);

    // Weight settings: zero (acts as one), one, both extremes, then a random pair
    edge_set = '{8'd0, 8'd1,   8'd255, 8'd255, 8'($urandom_range(1, 254))};
    stop_set = '{8'd0, 8'd255, 8'd1,   8'd255, 8'($urandom_range(1, 254))};

    foreach (edge_set[p]) begin
      write_weight(REG_EDGE_WEIGHT, edge_set[p]);
      write_weight(REG_STOP_WEIGHT, stop_set[p]);
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        // stretches with no idling at all on either side
        if (n % 20 == 0) calm = ($urandom_range(0, 3) == 0);
        // hold off the sender once per phase until the pipe is empty
        if (n == RANDOM_PER_PHASE / 2) drain_meter();
        if (n == RANDOM_PER_PHASE / 4) begin
          // tick burst long enough to cross a decay boundary
          burst = $urandom_range(64, 70);
          repeat (burst) begin
            b = random_beat();
            b.cmd = CMD_TICK;
            drive_beat(b, 1'b0);
          end
        end
        drive_beat(random_beat(), 1'b0);
      end
    end

    calm = 1'b0;
    repeat (5) drive_beat(random_beat(), 1'b0);

    drain_meter();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  // Watchdog over the whole run
  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("DONE: errors detected");
    $finish;
  end

endmodule
